// ===== sv/rgb565_scaler_fade_edge_blend_core_assert.svh =====
// assertion macros for the port-level checker file
`ifndef RGB565_SCALER_FADE_EDGE_BLEND_CORE_ASSERT_SVH
`define RGB565_SCALER_FADE_EDGE_BLEND_CORE_ASSERT_SVH

// concurrent assertion that is switched off while reset is high
`define RSFEB_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent assertion that also checks during reset
`define RSFEB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rsfeb_pkg.sv =====
// shared sizes, codes, types and arithmetic helpers of the image scaler
package rsfeb_pkg;

  // image geometry
  localparam int SRC_SIZE      = 160;
  localparam int DST_SIZE      = 180;
  localparam int EDGE_WIDTH    = 8;
  localparam int SCREEN_HEIGHT = 240;

  localparam int PIX_COUNT = SRC_SIZE * SRC_SIZE;
  localparam int ADDR_W    = $clog2(PIX_COUNT);
  localparam int SCOORD_W  = $clog2(SRC_SIZE);
  localparam int DCOORD_W  = $clog2(DST_SIZE);

  // coordinate mapping dst*SRC/DST by reciprocal multiply (ceil multiplier, exact)
  localparam int     MAP_SHIFT  = 2 * DCOORD_W + 1;
  localparam longint MAP_MULT   = ((longint'(SRC_SIZE) << MAP_SHIFT) + DST_SIZE - 1) / DST_SIZE;
  localparam int     MAP_MULT_W = $clog2(MAP_MULT + 1);
  localparam int     MAP_PROD_W = DCOORD_W + MAP_MULT_W;

  // blend weight A out of ALPHA_DEN
  localparam int ALPHA_DEN = 10 * EDGE_WIDTH;
  localparam int ALPHA_W   = $clog2(ALPHA_DEN + 1);

  // screen row of a rendered pixel
  localparam int SROW_W = ((DCOORD_W > 8) ? DCOORD_W : 8) + 1;

  // gradient numerator and its division by the screen height
  localparam int     GNUM_W      = 8 + SROW_W + $clog2(SCREEN_HEIGHT) + 2;
  localparam int     GRAD_LIM    = 256 * SCREEN_HEIGHT;
  localparam int     GLIM_W      = $clog2(GRAD_LIM);
  localparam int     GRAD_SHIFT  = GLIM_W + $clog2(SCREEN_HEIGHT) + 1;
  localparam longint GRAD_MULT   = ((longint'(1) << GRAD_SHIFT) + SCREEN_HEIGHT - 1)
                                   / SCREEN_HEIGHT;
  localparam int     GRAD_MULT_W = $clog2(GRAD_MULT + 1);
  localparam int     GPROD_W     = GLIM_W + GRAD_MULT_W;

  // blend numerator and its division by ALPHA_DEN
  localparam int     MIX_LIM    = 256 * ALPHA_DEN;
  localparam int     MLIM_W     = $clog2(MIX_LIM);
  localparam int     MIX_SHIFT  = MLIM_W + $clog2(ALPHA_DEN) + 1;
  localparam longint MIX_MULT   = ((longint'(1) << MIX_SHIFT) + ALPHA_DEN - 1) / ALPHA_DEN;
  localparam int     MIX_MULT_W = $clog2(MIX_MULT + 1);
  localparam int     MPROD_W    = MLIM_W + MIX_MULT_W;

  // fade divide by 7: x*293 >> 11 is exact for x up to 63*7
  localparam int FADE_PROD_W = 9;
  localparam int FADE_MULT   = 293;
  localparam int FADE_SHIFT  = 11;
  localparam int FADE_DIV_W  = FADE_PROD_W + 9;

  // item codes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  localparam logic [1:0] MODE_PLAIN = 2'd0;
  localparam logic [1:0] MODE_FADE  = 2'd1;
  localparam logic [1:0] MODE_EDGE  = 2'd2;

  localparam logic [1:0] KIND_PLAIN = 2'd0;
  localparam logic [1:0] KIND_FADE  = 2'd1;
  localparam logic [1:0] KIND_BLEND = 2'd2;

  // register indexes
  localparam int               CFG_INDEX_W     = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW_TOP  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAD_TOP    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_GRAD_BOTTOM = 2'd2;
  localparam logic [7:0]       WINDOW_TOP_RESET = 8'd40;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic                 is_render;
    logic [ADDR_W-1:0]    addr;
    logic [15:0]          wr_pixel;
    logic [SCOORD_W-1:0]  src_row;
    logic [SCOORD_W-1:0]  src_col;
    logic [DCOORD_W-1:0]  row;
    logic [1:0]           kind;
    logic [2:0]           level;
    logic [ALPHA_W-1:0]   alpha;
  } queue_entry_t;

  // floor(dst*SRC_SIZE/DST_SIZE)
  function automatic logic [SCOORD_W-1:0] map_coord(input logic [DCOORD_W-1:0] dst);
    logic [MAP_PROD_W-1:0] prod;
    logic [SCOORD_W-1:0]   q;
    prod = MAP_PROD_W'(dst) * MAP_PROD_W'(MAP_MULT);
    q = SCOORD_W'(prod >> MAP_SHIFT);
    if (q > SCOORD_W'(SRC_SIZE - 1)) q = SCOORD_W'(SRC_SIZE - 1);
    return q;
  endfunction

  function automatic logic [FADE_PROD_W-1:0] fade_prod(input logic [5:0] c,
                                                       input logic [2:0] level);
    return FADE_PROD_W'(c) * FADE_PROD_W'(level);
  endfunction

  function automatic logic [5:0] fade_div(input logic [FADE_PROD_W-1:0] x);
    logic [FADE_DIV_W-1:0] p;
    p = FADE_DIV_W'(x) * FADE_DIV_W'(FADE_MULT);
    return 6'(p >> FADE_SHIFT);
  endfunction

  // top*H + (bottom-top)*srow
  function automatic logic signed [GNUM_W-1:0] grad_num(input logic [7:0] top,
                                                        input logic [7:0] bot,
                                                        input logic [SROW_W-1:0] srow);
    logic signed [GNUM_W-1:0] t;
    logic signed [GNUM_W-1:0] b;
    logic signed [GNUM_W-1:0] s;
    logic signed [GNUM_W-1:0] h;
    t = GNUM_W'(top);
    b = GNUM_W'(bot);
    s = GNUM_W'(srow);
    h = GNUM_W'(SCREEN_HEIGHT);
    return t * h + (b - t) * s;
  endfunction

  // floor(num/H) saturated to 0..255
  function automatic logic [7:0] grad_div(input logic signed [GNUM_W-1:0] num);
    logic signed [GNUM_W-1:0] lim;
    logic [GPROD_W-1:0]       p;
    logic [7:0]               q;
    lim = GNUM_W'(GRAD_LIM);
    p = GPROD_W'(num[GLIM_W-1:0]) * GPROD_W'(GRAD_MULT);
    if (num < 0) q = 8'd0;
    else if (num >= lim) q = 8'd255;
    else q = 8'(p >> GRAD_SHIFT);
    return q;
  endfunction

  // c8*A + bg*(DEN-A)
  function automatic logic [MLIM_W-1:0] mix_num(input logic [7:0] c8, input logic [7:0] bg,
                                                input logic [ALPHA_W-1:0] alpha);
    return MLIM_W'(c8) * MLIM_W'(alpha)
         + MLIM_W'(bg) * (MLIM_W'(ALPHA_DEN) - MLIM_W'(alpha));
  endfunction

  function automatic logic [7:0] mix_div(input logic [MLIM_W-1:0] n);
    logic [MPROD_W-1:0] p;
    p = MPROD_W'(n) * MPROD_W'(MIX_MULT);
    return 8'(p >> MIX_SHIFT);
  endfunction

endpackage

// ===== sv/rgb565_scaler_fade_edge_blend_core.sv =====
// top level of the rgb565 nearest-neighbour upscaler with fade and edge blend
//
//   channel  direction  handshake             payload
//   in       input      in_valid / in_stall   op, source_address, source_pixel, out_row,
//                                             out_col, render_mode, fade_level
//   out      output     out_valid / out_stall pixel_out
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while the output is not held; a render result passes through the
// queue, the ram read, three arithmetic stages and the output register.
// writes pass through the queue before they take effect in the ram.
// synchronous reset clears the queue and the pipeline valids and resets the config registers.
// a held output stalls the whole back end; the four-entry queue then fills and
// raises in_stall. cfg_ready is always high.
module rgb565_scaler_fade_edge_blend_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              op,
  input  logic [14:0]                       source_address,
  input  logic [15:0]                       source_pixel,
  input  logic [7:0]                        out_row,
  input  logic [7:0]                        out_col,
  input  logic [1:0]                        render_mode,
  input  logic [2:0]                        fade_level,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       pixel_out,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsfeb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                       cfg_data
);
  import rsfeb_pkg::*;

  logic         push;
  queue_entry_t push_entry;
  queue_entry_t head;
  logic         q_empty;
  logic         q_full;
  logic         q_pop;

  assign in_stall = q_full;

  // classify and map incoming items
  rsfeb_front u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .op             (op),
    .source_address (source_address),
    .source_pixel   (source_pixel),
    .out_row        (out_row),
    .out_col        (out_col),
    .render_mode    (render_mode),
    .fade_level     (fade_level),
    .push           (push),
    .entry          (push_entry)
  );

  // decoupling queue
  rsfeb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full)
  );

  // memory access and render pipeline
  rsfeb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .q_empty   (q_empty),
    .q_head    (head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .pixel_out (pixel_out)
  );

endmodule

// ===== sv/rsfeb_ram.sv =====
// generic single-port ram with registered read
module rsfeb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ===== sv/rsfeb_front.sv =====
// front end: accepts items, maps coordinates and classifies the render kind
module rsfeb_front (
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  logic                   op,
  input  logic [14:0]            source_address,
  input  logic [15:0]            source_pixel,
  input  logic [7:0]             out_row,
  input  logic [7:0]             out_col,
  input  logic [1:0]             render_mode,
  input  logic [2:0]             fade_level,
  output logic                   push,
  output rsfeb_pkg::queue_entry_t entry
);
  import rsfeb_pkg::*;

  logic [DCOORD_W-1:0] row_sat;
  logic [DCOORD_W-1:0] col_sat;
  logic [DCOORD_W-1:0] d_row;
  logic [DCOORD_W-1:0] d_col;
  logic [DCOORD_W-1:0] border_dist;
  logic                near;
  logic                wr_ok;
  logic [1:0]          kind;

  // clamp coordinates to the output image
  assign row_sat = (int'(out_row) > DST_SIZE - 1) ? DCOORD_W'(DST_SIZE - 1) : DCOORD_W'(out_row);
  assign col_sat = (int'(out_col) > DST_SIZE - 1) ? DCOORD_W'(DST_SIZE - 1) : DCOORD_W'(out_col);

  // distance to the nearest border
  always_comb begin
    d_row = DCOORD_W'(DST_SIZE - 1) - row_sat;
    if (row_sat < d_row) d_row = row_sat;
    d_col = DCOORD_W'(DST_SIZE - 1) - col_sat;
    if (col_sat < d_col) d_col = col_sat;
    border_dist = (d_col < d_row) ? d_col : d_row;
  end

  assign near = int'(border_dist) < EDGE_WIDTH;

  // render kind
  always_comb begin
    case (render_mode)
      MODE_FADE: kind = KIND_FADE;
      MODE_EDGE: kind = near ? KIND_BLEND : KIND_PLAIN;
      default:   kind = KIND_PLAIN;
    endcase
  end

  // writes past the image are dropped
  assign wr_ok = int'(source_address) < PIX_COUNT;
  assign push  = in_valid && !in_stall && ((op == OP_RENDER) || wr_ok);

  // queue entry
  always_comb begin
    entry.is_render = (op == OP_RENDER);
    entry.addr      = ADDR_W'(source_address);
    entry.wr_pixel  = source_pixel;
    entry.src_row   = map_coord(row_sat);
    entry.src_col   = map_coord(col_sat);
    entry.row       = row_sat;
    entry.kind      = kind;
    entry.level     = fade_level;
    entry.alpha     = ALPHA_W'(3 * EDGE_WIDTH + 7 * int'(border_dist));
  end

endmodule

// ===== sv/rsfeb_queue.sv =====
// short fifo between front and back
module rsfeb_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  rsfeb_pkg::queue_entry_t push_entry,
  input  logic                    pop,
  output rsfeb_pkg::queue_entry_t head,
  output logic                    empty,
  output logic                    full
);
  import rsfeb_pkg::*;

  queue_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QPTR_W:0]     count;

  assign empty = (count == '0);
  assign full  = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign head  = slots[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (pop)  rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

endmodule

// ===== sv/rsfeb_back.sv =====
// back end: source image ram, config registers and the render pipeline
module rsfeb_back (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rsfeb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                       cfg_data,
  input  logic                              q_empty,
  input  rsfeb_pkg::queue_entry_t           q_head,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [15:0]                       pixel_out
);
  import rsfeb_pkg::*;

  logic [7:0]  window_top;
  logic [23:0] grad_top;
  logic [23:0] grad_bottom;

  logic              advance;
  logic              ram_we;
  logic              ram_re;
  logic [ADDR_W-1:0] rd_addr;
  logic [ADDR_W-1:0] ram_addr;
  logic [15:0]       ram_rdata;

  // stage 1: ram read
  logic               v1;
  logic [1:0]         kind1;
  logic [2:0]         level1;
  logic [ALPHA_W-1:0] alpha1;
  logic [SROW_W-1:0]  srow1;

  // stage 2: products
  logic                     v2;
  logic [1:0]               kind2;
  logic [15:0]              pix2;
  logic [ALPHA_W-1:0]       alpha2;
  logic [FADE_PROD_W-1:0]   fx_r, fx_g, fx_b;
  logic signed [GNUM_W-1:0] gn_r, gn_g, gn_b;

  // stage 3: divides
  logic               v3;
  logic [1:0]         kind3;
  logic [15:0]        pix3;
  logic [ALPHA_W-1:0] alpha3;
  logic [15:0]        fade3;
  logic [7:0]         bg_r, bg_g, bg_b;
  logic [5:0]         fd_r, fd_g, fd_b;

  // stage 4: blend numerators
  logic              v4;
  logic [1:0]        kind4;
  logic [15:0]       pix4;
  logic [15:0]       fade4;
  logic [MLIM_W-1:0] mn_r, mn_g, mn_b;

  logic [7:0]  m_r, m_g, m_b;
  logic [15:0] result;

  assign cfg_ready = 1'b1;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      window_top  <= WINDOW_TOP_RESET;
      grad_top    <= '0;
      grad_bottom <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_WINDOW_TOP:  window_top  <= cfg_data[7:0];
        REG_GRAD_TOP:    grad_top    <= cfg_data;
        REG_GRAD_BOTTOM: grad_bottom <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline moves as a whole unless the output is held
  assign advance = !out_valid || !out_stall;
  assign q_pop   = advance && !q_empty;
  assign ram_we  = q_pop && !q_head.is_render;
  assign ram_re  = q_pop && q_head.is_render;
  assign rd_addr = ADDR_W'(ADDR_W'(q_head.src_row) * ADDR_W'(SRC_SIZE))
                 + ADDR_W'(q_head.src_col);
  assign ram_addr = q_head.is_render ? rd_addr : q_head.addr;

  rsfeb_ram #(
    .WIDTH (16),
    .DEPTH (PIX_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (q_head.wr_pixel),
    .rdata (ram_rdata)
  );

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      v1        <= ram_re;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      out_valid <= v4;
    end
  end

  // stage 1 side data
  always_ff @(posedge clk) begin
    if (advance) begin
      kind1  <= q_head.kind;
      level1 <= q_head.level;
      alpha1 <= q_head.alpha;
      srow1  <= SROW_W'(window_top) + SROW_W'(q_head.row);
    end
  end

  // stage 2: fade products and gradient numerators
  always_ff @(posedge clk) begin
    if (advance) begin
      kind2  <= kind1;
      pix2   <= ram_rdata;
      alpha2 <= alpha1;
      fx_r   <= fade_prod({1'b0, ram_rdata[15:11]}, level1);
      fx_g   <= fade_prod(ram_rdata[10:5], level1);
      fx_b   <= fade_prod({1'b0, ram_rdata[4:0]}, level1);
      gn_r   <= grad_num(grad_top[23:16], grad_bottom[23:16], srow1);
      gn_g   <= grad_num(grad_top[15:8], grad_bottom[15:8], srow1);
      gn_b   <= grad_num(grad_top[7:0], grad_bottom[7:0], srow1);
    end
  end

  // fade quotients
  assign fd_r = fade_div(fx_r);
  assign fd_g = fade_div(fx_g);
  assign fd_b = fade_div(fx_b);

  // stage 3: fade divide and background channels
  always_ff @(posedge clk) begin
    if (advance) begin
      kind3  <= kind2;
      pix3   <= pix2;
      alpha3 <= alpha2;
      fade3  <= {fd_r[4:0], fd_g, fd_b[4:0]};
      bg_r   <= grad_div(gn_r);
      bg_g   <= grad_div(gn_g);
      bg_b   <= grad_div(gn_b);
    end
  end

  // stage 4: blend numerators
  always_ff @(posedge clk) begin
    if (advance) begin
      kind4 <= kind3;
      pix4  <= pix3;
      fade4 <= fade3;
      mn_r  <= mix_num({pix3[15:11], 3'b000}, bg_r, alpha3);
      mn_g  <= mix_num({pix3[10:5], 2'b00}, bg_g, alpha3);
      mn_b  <= mix_num({pix3[4:0], 3'b000}, bg_b, alpha3);
    end
  end

  // blend divide and result select
  assign m_r = mix_div(mn_r);
  assign m_g = mix_div(mn_g);
  assign m_b = mix_div(mn_b);

  always_comb begin
    case (kind4)
      KIND_FADE:  result = fade4;
      KIND_BLEND: result = {m_r[7:3], m_g[7:2], m_b[7:3]};
      default:    result = pix4;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (advance) begin
      pixel_out <= result;
    end
  end

endmodule

// ===== sv/rsfeb_checker.sv =====
// port-level checker for the scaler core and its bind
`include "rgb565_scaler_fade_edge_blend_core_assert.svh"

module rsfeb_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] pixel_out
);

  // a held result stays put
  `RSFEB_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(pixel_out), "held result changed")

  // nothing comes out right after reset, the pipeline has to fill first
  `RSFEB_ASSERT_ALWAYS(a_out_quiet, clk, rst |=> !out_valid ##1 !out_valid, "result too soon after reset")

  // the queue is empty after reset so input is open
  `RSFEB_ASSERT_ALWAYS(a_in_open, clk, rst |=> !in_stall, "input stalled after reset")

endmodule

bind rgb565_scaler_fade_edge_blend_core rsfeb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .pixel_out (pixel_out)
);

// ===== tb/sv/rsfeb_pixel_checker.sv =====
// checker for the rgb565 upscaler: predicts rendered pixels and compares them with pixel_out
`timescale 1ns / 100ps

module rsfeb_pixel_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic                              op,
  input  logic [14:0]                       source_address,
  input  logic [15:0]                       source_pixel,
  input  logic [7:0]                        out_row,
  input  logic [7:0]                        out_col,
  input  logic [1:0]                        render_mode,
  input  logic [2:0]                        fade_level,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [15:0]                       pixel_out,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [rsfeb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [23:0]                       cfg_data,
  output int                                errors,
  output int                                pending
);
  import rsfeb_pkg::*;

  localparam int FADE_FULL = 7;

  // shadow copy of the source image and the registers
  logic [15:0] src_image [PIX_COUNT];
  logic [7:0]  window_top;
  logic [23:0] grad_top;
  logic [23:0] grad_bottom;

  // rendered pixels still owed by the block, oldest first
  logic [15:0] expected_pixels [$];

  int fail_count = 0;
  int waiting = 0;

  assign errors  = fail_count;
  assign pending = waiting;

  // nearest-neighbour source coordinate of an output coordinate
  function automatic int dst_to_src(int dst);
    int s;
    s = dst * SRC_SIZE / DST_SIZE;
    if (s > SRC_SIZE - 1) s = SRC_SIZE - 1;
    return s;
  endfunction

  // background channel on the vertical gradient at screen row srow, clamped to 0..255
  function automatic int gradient_level(int top, int bot, int srow);
    int num;
    num = top * SCREEN_HEIGHT + (bot - top) * srow;
    if (num <= 0) return 0;
    if (num / SCREEN_HEIGHT > 255) return 255;
    return num / SCREEN_HEIGHT;
  endfunction

  // weighted mix of an 8-bit channel with the background, floor
  function automatic int blend_channel(int c8, int bg, int alpha);
    return (c8 * alpha + bg * (ALPHA_DEN - alpha)) / ALPHA_DEN;
  endfunction

  function automatic logic [15:0] render_pixel(logic [7:0] row_in, logic [7:0] col_in,
                                               logic [1:0] mode, logic [2:0] level);
    int row, col, border_dist, alpha, srow, lvl;
    int r, g, b;
    logic [15:0] pix;
    logic [15:0] res;
    // coordinates past the output edge clamp to the last row or column
    row = (row_in > DST_SIZE - 1) ? DST_SIZE - 1 : row_in;
    col = (col_in > DST_SIZE - 1) ? DST_SIZE - 1 : col_in;
    pix = src_image[dst_to_src(row) * SRC_SIZE + dst_to_src(col)];
    r = pix[15:11];
    g = pix[10:5];
    b = pix[4:0];
    lvl = level;
    res = pix;
    case (mode)
      MODE_FADE: begin
        res = {5'(r * lvl / FADE_FULL), 6'(g * lvl / FADE_FULL), 5'(b * lvl / FADE_FULL)};
      end
      MODE_EDGE: begin
        border_dist = row;
        if (DST_SIZE - 1 - row < border_dist) border_dist = DST_SIZE - 1 - row;
        if (col < border_dist) border_dist = col;
        if (DST_SIZE - 1 - col < border_dist) border_dist = DST_SIZE - 1 - col;
        // only the border band is blended, the interior passes through
        if (border_dist < EDGE_WIDTH) begin
          alpha = 3 * EDGE_WIDTH + 7 * border_dist;
          srow = window_top + row;
          r = blend_channel(r << 3, gradient_level(grad_top[23:16], grad_bottom[23:16], srow),
                            alpha) >> 3;
          g = blend_channel(g << 2, gradient_level(grad_top[15:8], grad_bottom[15:8], srow),
                            alpha) >> 2;
          b = blend_channel(b << 3, gradient_level(grad_top[7:0], grad_bottom[7:0], srow),
                            alpha) >> 3;
          res = {5'(r), 6'(g), 5'(b)};
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  // watch all three channels at each edge
  always @(posedge clk) begin
    logic [15:0] want;
    if (rst) begin
      window_top  = WINDOW_TOP_RESET;
      grad_top    = '0;
      grad_bottom = '0;
      expected_pixels.delete();
    end else begin
      // result transfer against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel_out: expected nothing, actual %h", pixel_out);
          fail_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (pixel_out !== want) begin
            $error("pixel_out: expected %h, actual %h", want, pixel_out);
            fail_count++;
          end
        end
      end
      // register write
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_WINDOW_TOP:  window_top  = cfg_data[7:0];
          REG_GRAD_TOP:    grad_top    = cfg_data;
          REG_GRAD_BOTTOM: grad_bottom = cfg_data;
          default: ;
        endcase
      end
      // input transfer: store a pixel or predict a render
      if (in_valid && !in_stall) begin
        if (op == OP_WRITE) begin
          if (source_address < PIX_COUNT) src_image[source_address] = source_pixel;
        end else begin
          expected_pixels.push_back(render_pixel(out_row, out_col, render_mode, fade_level));
        end
      end
    end
    waiting = expected_pixels.size();
  end

endmodule

// ===== tb/sv/rgb565_scaler_fade_edge_blend_core_test.sv =====
// stimulus and verdict for the rgb565 upscaler core
`timescale 1ns / 100ps

module rgb565_scaler_fade_edge_blend_core_test;
  import rsfeb_pkg::*;

  localparam logic [1:0]             MODE_UNUSED  = 2'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED   = 2'd3;
  localparam int SEGMENTS      = 8;
  localparam int SEG_ITEMS     = 205;
  localparam int HOLD_CYCLES   = 300;
  localparam int HOLD_BURST    = 40;
  localparam int SETTLE_CYCLES = 12;
  localparam int RUN_LIMIT_NS  = 2_000_000;

  logic                   clk            = 1'b0;
  logic                   rst            = 1'b1;
  logic                   in_valid       = 1'b0;
  logic                   in_stall;
  logic                   op             = 1'b0;
  logic [14:0]            source_address = '0;
  logic [15:0]            source_pixel   = '0;
  logic [7:0]             out_row        = '0;
  logic [7:0]             out_col        = '0;
  logic [1:0]             render_mode    = '0;
  logic [2:0]             fade_level     = '0;
  logic                   out_valid;
  logic                   out_stall      = 1'b0;
  logic [15:0]            pixel_out;
  logic                   cfg_valid      = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index      = '0;
  logic [23:0]            cfg_data       = '0;

  int mismatch_count;
  int pending_pixels;

  // which source pixels hold a value, so no render reads an unwritten one
  bit written [PIX_COUNT];
  int useful = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  bit hold_req = 1'b0;

  rgb565_scaler_fade_edge_blend_core dut (.*);

  rsfeb_pixel_checker pixel_check (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .op(op),
    .source_address(source_address), .source_pixel(source_pixel), .out_row(out_row),
    .out_col(out_col), .render_mode(render_mode), .fade_level(fade_level),
    .out_valid(out_valid), .out_stall(out_stall), .pixel_out(pixel_out),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .errors(mismatch_count), .pending(pending_pixels)
  );

  always #5 clk = ~clk;

  // run limit
  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  function automatic int src_of(logic [7:0] dst);
    int d;
    int s;
    d = (dst > DST_SIZE - 1) ? DST_SIZE - 1 : dst;
    s = d * SRC_SIZE / DST_SIZE;
    return (s > SRC_SIZE - 1) ? SRC_SIZE - 1 : s;
  endfunction

  // output coordinate biased toward the border band and past the edge
  function automatic logic [7:0] pick_coord();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 8'($urandom_range(255, DST_SIZE));
    if (sel < 25) return 8'($urandom_range(EDGE_WIDTH + 1));
    if (sel < 40) return 8'(DST_SIZE - 1 - $urandom_range(EDGE_WIDTH + 1));
    return 8'($urandom_range(DST_SIZE - 1));
  endfunction

  function automatic logic [15:0] pick_pixel();
    int sel;
    sel = $urandom_range(9);
    if (sel == 0) return 16'hFFFF;
    if (sel == 1) return 16'h0000;
    return 16'($urandom);
  endfunction

  function automatic logic [1:0] pick_mode();
    int sel;
    sel = $urandom_range(99);
    if (sel < 40) return MODE_EDGE;
    if (sel < 60) return MODE_FADE;
    if (sel < 90) return MODE_PLAIN;
    return MODE_UNUSED;
  endfunction

  // one input transfer, with random idle cycles ahead of it
  task automatic offer(logic o, logic [14:0] a, logic [15:0] p, logic [7:0] r,
                       logic [7:0] c, logic [1:0] m, logic [2:0] l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid       <= 1'b1;
    op             <= o;
    source_address <= a;
    source_pixel   <= p;
    out_row        <= r;
    out_col        <= c;
    render_mode    <= m;
    fade_level     <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (o == OP_WRITE && a < PIX_COUNT) written[a] = 1'b1;
    if (o == OP_RENDER || a < PIX_COUNT) useful++;
  endtask

  // render one output pixel, loading its source pixel first if still unwritten
  task automatic render_at(logic [7:0] r, logic [7:0] c, logic [1:0] m, logic [2:0] l);
    int spot;
    spot = src_of(r) * SRC_SIZE + src_of(c);
    if (!written[spot]) offer(OP_WRITE, 15'(spot), pick_pixel(), r, c, m, l);
    offer(OP_RENDER, 15'($urandom), 16'($urandom), r, c, m, l);
  endtask

  // stop offering, wait for every owed pixel, then let the pipeline settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_pixels != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_put(logic [CFG_INDEX_W-1:0] idx, logic [23:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // all registers, junk in the unused window bits and a write to the spare index
  task automatic program_regs(logic [7:0] win, logic [23:0] top, logic [23:0] bot);
    cfg_put(REG_WINDOW_TOP, {16'($urandom), win});
    cfg_put(REG_GRAD_TOP, top);
    cfg_put(REG_GRAD_BOTTOM, bot);
    cfg_put(REG_UNUSED, 24'($urandom));
    cfg_valid <= 1'b0;
  endtask

  initial begin : stimulus
    int sel;
    int target;
    logic [7:0] row_v;
    logic [7:0] col_v;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed part under the reset register values
    offer(OP_WRITE, 15'd0, 16'hFFFF, 8'd0, 8'd0, MODE_PLAIN, 3'd0);
    offer(OP_WRITE, 15'(PIX_COUNT - 1), 16'hF81F, 8'hFF, 8'hFF, MODE_UNUSED, 3'd7);
    offer(OP_WRITE, 15'd1, 16'h0000, 8'd0, 8'd0, MODE_PLAIN, 3'd0);
    // writes past the end of the image are dropped
    offer(OP_WRITE, 15'h7FFF, 16'h0000, 8'd0, 8'd0, MODE_PLAIN, 3'd0);
    offer(OP_WRITE, 15'(PIX_COUNT), 16'h0000, 8'd0, 8'd0, MODE_PLAIN, 3'd0);
    render_at(8'd0, 8'd0, MODE_PLAIN, 3'd0);
    render_at(8'd0, 8'd0, MODE_FADE, 3'd0);
    render_at(8'd0, 8'd0, MODE_FADE, 3'd7);
    render_at(8'd0, 8'd0, MODE_FADE, 3'd3);
    render_at(8'd0, 8'd0, MODE_EDGE, 3'd0);
    render_at(8'd0, 8'd0, MODE_UNUSED, 3'd0);
    render_at(8'd0, 8'd2, MODE_PLAIN, 3'd0);
    render_at(8'd179, 8'd179, MODE_PLAIN, 3'd0);
    // coordinates past the output edge clamp
    render_at(8'hFF, 8'hFF, MODE_EDGE, 3'd0);
    render_at(8'hFF, 8'd0, MODE_FADE, 3'd5);
    // both sides of the border band
    render_at(8'd7, 8'd90, MODE_EDGE, 3'd0);
    render_at(8'd8, 8'd90, MODE_EDGE, 3'd0);
    render_at(8'd90, 8'd172, MODE_EDGE, 3'd0);
    render_at(8'd90, 8'd171, MODE_EDGE, 3'd0);
    render_at(8'd90, 8'd90, MODE_EDGE, 3'd0);

    for (int seg = 0; seg < SEGMENTS; seg++) begin
      drain();
      case (seg)
        0: program_regs(8'd0, 24'hFFFFFF, 24'h000000);
        1: program_regs(8'd239, 24'h000000, 24'hFFFFFF);
        2: program_regs(8'd255, 24'hFF00FF, 24'h00FF00);
        3: program_regs(8'd40, 24'h00FF00, 24'hFF00FF);
        default: program_regs(8'($urandom), 24'($urandom), 24'($urandom));
      endcase
      case (seg % 4)
        0: begin send_idle_pct = 0;  stall_pct = 0;  end
        1: begin send_idle_pct = 60; stall_pct = 0;  end
        2: begin send_idle_pct = 0;  stall_pct = 60; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase

      // long receiver hold while renders keep coming, so the input backs up
      if (seg % 4 == 0) begin
        hold_req = 1'b1;
        repeat (HOLD_BURST) render_at(pick_coord(), pick_coord(), pick_mode(), 3'($urandom));
      end

      target = useful + SEG_ITEMS;
      while (useful < target) begin
        sel = $urandom_range(99);
        if (sel < 10) begin
          // write past the image end
          offer(OP_WRITE, 15'($urandom_range(32767, PIX_COUNT)), 16'($urandom),
                8'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
        end else if (sel < 45) begin
          offer(OP_WRITE, 15'($urandom_range(PIX_COUNT - 1)), pick_pixel(),
                8'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
        end else if (sel < 55) begin
          // overwrite a pixel and render it right after
          row_v = pick_coord();
          col_v = pick_coord();
          offer(OP_WRITE, 15'(src_of(row_v) * SRC_SIZE + src_of(col_v)), pick_pixel(),
                8'($urandom), 8'($urandom), 2'($urandom), 3'($urandom));
          render_at(row_v, col_v, pick_mode(), 3'($urandom));
        end else begin
          render_at(pick_coord(), pick_coord(), pick_mode(), 3'($urandom));
        end
      end
    end

    drain();
    if (mismatch_count == 0 && pending_pixels == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
